@@ rtl/lmsc_pkg.sv @@
// Package for the LED matrix scan controller.
// Holds shared widths, frame selector codes and latch target codes.
// No dependencies.
`timescale 1ns / 1ps

package lmsc_pkg;

   localparam int BYTE_W   = 8;
   localparam int TARGET_W = 3;
   localparam int IDX_W    = 3;
   localparam int ROWS     = 8;
   localparam int PAIRS    = 4;

   // frame selectors: Q/W/E/R load matrix column pairs; SEL_FWD loads LED row 8 and forwards
   localparam logic [BYTE_W-1:0] SEL_Q   = 8'h71;
   localparam logic [BYTE_W-1:0] SEL_W   = 8'h77;
   localparam logic [BYTE_W-1:0] SEL_E   = 8'h65;
   localparam logic [BYTE_W-1:0] SEL_R   = 8'h72;
   localparam logic [BYTE_W-1:0] SEL_FWD = 8'd8;

   // request kinds
   localparam logic REQ_SERIAL = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef enum logic [TARGET_W-1:0] {
      TGT_LED_COL    = 3'd0,
      TGT_LED_ROW_LO = 3'd1,
      TGT_LED_ROW_HI = 3'd2,
      TGT_MTX_COMMON = 3'd3,
      TGT_RED        = 3'd4,
      TGT_BLUE       = 3'd5,
      TGT_GREEN      = 3'd6,
      TGT_FWD_UART   = 3'd7
   } target_type;

endpackage

@@ rtl/lmsc_if.sv @@
// Valid/ready channel interfaces for the scan controller request and response.
// Depends on lmsc_pkg.
`timescale 1ns / 1ps

interface lmsc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [lmsc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lmsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lmsc_pkg::BYTE_W-1:0]   out_byte;
   logic [lmsc_pkg::TARGET_W-1:0] latch_target;
   logic                          last;

   modport source (output valid, output out_byte, output latch_target, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input latch_target, input last,
                   output ready);
endinterface

@@ rtl/led_matrix_scan_controller_top.sv @@
// Latency: a tick's first write is offered the cycle after its transfer; writes follow
// one per cycle while rsp.ready holds, 9 per tick, 10 when the pending frame forwards
// a byte to the UART. Throughput: the single write sequencer runs one tick at a time
// and takes the next on the final write's transfer. Serial bytes are taken each cycle.
// Reset (synchronous, active high) clears counters, frame state and the valid bits of
// the row and matrix memories, so unwritten entries read as zero. No clearing pass.
`timescale 1ns / 1ps

module led_matrix_scan_controller_top (
   input  logic       clock,
   input  logic       reset,
   lmsc_req_if.sink   req,
   lmsc_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      STEP_CLEAR_COL,
      STEP_ROW_LO,
      STEP_ROW_HI,
      STEP_ROW_SEL,
      STEP_CLEAR_COM,
      STEP_COLOR_A,
      STEP_COLOR_B,
      STEP_COLOR_C,
      STEP_COL_SEL,
      STEP_FWD
   } step_type;

   localparam int BW = lmsc_pkg::BYTE_W;
   localparam int IW = lmsc_pkg::IDX_W;

   // state memories: led rows 8 x 16, matrix columns as 4 pairs x 16
   logic [2*BW-1:0] led_mem [lmsc_pkg::ROWS];
   logic [2*BW-1:0] mtx_mem [lmsc_pkg::PAIRS];
   logic [lmsc_pkg::ROWS-1:0]  led_vld_ff;
   logic [lmsc_pkg::PAIRS-1:0] mtx_vld_ff;
   logic [2*BW-1:0] led_rd_ff;
   logic [2*BW-1:0] mtx_rd_ff;

   logic            busy_ff;
   step_type        step_ff, step_in;
   logic [IW-1:0]   row_ff, col_ff;
   logic [IW-1:0]   y_ff, z_ff;
   logic            fwd_ff;
   logic [BW-1:0]   fwd_byte_ff;
   logic [BW-1:0]   frame_ff [3];
   logic [1:0]      count_ff;
   logic            pending_ff;

   logic            rsp_xfer, last_xfer, tick_ready;
   logic            tick_xfer, byte_xfer;
   logic [BW-1:0]   sel;
   logic            led_we, mtx_we;
   logic [IW-1:0]   led_waddr;
   logic [1:0]      mtx_waddr;
   logic [BW-1:0]   m_byte;
   logic [BW-1:0]   row_bit, col_bit;

   assign rsp_xfer   = rsp.valid && rsp.ready;
   assign last_xfer  = rsp_xfer && rsp.last;
   assign tick_ready = !busy_ff || last_xfer;
   assign req.ready  = (req.req_type == lmsc_pkg::REQ_TICK) ? tick_ready : 1'b1;
   assign tick_xfer  = req.valid && req.ready && (req.req_type == lmsc_pkg::REQ_TICK);
   assign byte_xfer  = req.valid && req.ready && (req.req_type == lmsc_pkg::REQ_SERIAL);

   // frame decode; applied at the tick transfer, after that tick's reads
   assign sel = frame_ff[2];
   always_comb begin
      led_we    = 1'b0;
      mtx_we    = 1'b0;
      led_waddr = IW'(sel - 8'd1);
      mtx_waddr = 2'd0;
      unique case (sel) inside
         [8'd1:8'd8]: led_we = pending_ff;
         lmsc_pkg::SEL_Q: begin
            mtx_we    = pending_ff;
            mtx_waddr = 2'd3;
         end
         lmsc_pkg::SEL_W: begin
            mtx_we    = pending_ff;
            mtx_waddr = 2'd2;
         end
         lmsc_pkg::SEL_E: begin
            mtx_we    = pending_ff;
            mtx_waddr = 2'd1;
         end
         lmsc_pkg::SEL_R: begin
            mtx_we    = pending_ff;
            mtx_waddr = 2'd0;
         end
         default: ;
      endcase
   end

   // memories: read and write share the tick transfer edge; read returns the old
   // entry, which is the order the scan needs, so no forwarding is required
   always_ff @(posedge clock) begin
      if (tick_xfer) begin
         led_rd_ff <= led_vld_ff[row_ff] ? led_mem[row_ff] : '0;
         mtx_rd_ff <= mtx_vld_ff[col_ff[IW-1:1]] ? mtx_mem[col_ff[IW-1:1]] : '0;
         if (led_we) led_mem[led_waddr] <= {frame_ff[1], frame_ff[0]};
         // odd column in the high byte: byte0 goes to the odd column
         if (mtx_we) mtx_mem[mtx_waddr] <= {frame_ff[0], frame_ff[1]};
         y_ff        <= row_ff;
         z_ff        <= col_ff;
         fwd_byte_ff <= frame_ff[1];
      end
      if (byte_xfer && !pending_ff) begin
         case (count_ff)
            2'd1:    frame_ff[1] <= req.rx_byte;
            2'd2:    frame_ff[2] <= req.rx_byte;
            default: frame_ff[0] <= req.rx_byte;
         endcase
      end
   end

   always_comb begin
      unique case (step_ff)
         STEP_CLEAR_COL: step_in = STEP_ROW_LO;
         STEP_ROW_LO:    step_in = STEP_ROW_HI;
         STEP_ROW_HI:    step_in = STEP_ROW_SEL;
         STEP_ROW_SEL:   step_in = STEP_CLEAR_COM;
         STEP_CLEAR_COM: step_in = STEP_COLOR_A;
         STEP_COLOR_A:   step_in = STEP_COLOR_B;
         STEP_COLOR_B:   step_in = STEP_COLOR_C;
         STEP_COLOR_C:   step_in = STEP_COL_SEL;
         STEP_COL_SEL:   step_in = STEP_FWD;
         STEP_FWD:       step_in = STEP_CLEAR_COL;
         default:        step_in = STEP_CLEAR_COL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ff    <= STEP_CLEAR_COL;
         row_ff     <= '0;
         col_ff     <= '0;
         fwd_ff     <= 1'b0;
         count_ff   <= 2'd0;
         pending_ff <= 1'b0;
         led_vld_ff <= '0;
         mtx_vld_ff <= '0;
      end else begin
         if (tick_xfer) begin
            busy_ff    <= 1'b1;
            step_ff    <= STEP_CLEAR_COL;
            row_ff     <= row_ff + IW'(1);
            col_ff     <= col_ff - IW'(1);
            fwd_ff     <= pending_ff && (sel == lmsc_pkg::SEL_FWD);
            pending_ff <= 1'b0;
            if (led_we) led_vld_ff[led_waddr] <= 1'b1;
            if (mtx_we) mtx_vld_ff[mtx_waddr] <= 1'b1;
         end else if (rsp_xfer) begin
            if (rsp.last) busy_ff <= 1'b0;
            else          step_ff <= step_in;
         end
         if (byte_xfer && !pending_ff) begin
            if (count_ff >= 2'd2) begin
               count_ff   <= 2'd0;
               pending_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + 2'd1;
            end
         end
      end
   end

   assign m_byte  = z_ff[0] ? mtx_rd_ff[2*BW-1:BW] : mtx_rd_ff[BW-1:0];
   assign row_bit = BW'(1) << y_ff;
   assign col_bit = BW'(1) << z_ff;

   always_comb begin
      rsp.out_byte     = '0;
      rsp.latch_target = lmsc_pkg::TGT_LED_COL;
      unique case (step_ff)
         STEP_CLEAR_COL: rsp.latch_target = lmsc_pkg::TGT_LED_COL;
         STEP_ROW_LO: begin
            rsp.out_byte     = led_rd_ff[BW-1:0];
            rsp.latch_target = lmsc_pkg::TGT_LED_ROW_LO;
         end
         STEP_ROW_HI: begin
            rsp.out_byte     = led_rd_ff[2*BW-1:BW];
            rsp.latch_target = lmsc_pkg::TGT_LED_ROW_HI;
         end
         STEP_ROW_SEL: begin
            rsp.out_byte     = row_bit;
            rsp.latch_target = lmsc_pkg::TGT_LED_COL;
         end
         STEP_CLEAR_COM: rsp.latch_target = lmsc_pkg::TGT_MTX_COMMON;
         STEP_COLOR_A: begin
            rsp.out_byte = m_byte;
            case (z_ff[IW-1:1])
               2'd3:    rsp.latch_target = lmsc_pkg::TGT_BLUE;
               2'd0:    rsp.latch_target = lmsc_pkg::TGT_GREEN;
               default: rsp.latch_target = lmsc_pkg::TGT_RED;
            endcase
         end
         STEP_COLOR_B: begin
            case (z_ff[IW-1:1])
               2'd3:    rsp.latch_target = lmsc_pkg::TGT_RED;
               2'd1: begin
                  rsp.out_byte     = m_byte;
                  rsp.latch_target = lmsc_pkg::TGT_GREEN;
               end
               default: rsp.latch_target = lmsc_pkg::TGT_BLUE;
            endcase
         end
         STEP_COLOR_C: begin
            case (z_ff[IW-1:1])
               2'd1:    rsp.latch_target = lmsc_pkg::TGT_BLUE;
               2'd0:    rsp.latch_target = lmsc_pkg::TGT_RED;
               default: rsp.latch_target = lmsc_pkg::TGT_GREEN;
            endcase
         end
         STEP_COL_SEL: begin
            rsp.out_byte     = col_bit;
            rsp.latch_target = lmsc_pkg::TGT_MTX_COMMON;
         end
         STEP_FWD: begin
            rsp.out_byte     = fwd_byte_ff;
            rsp.latch_target = lmsc_pkg::TGT_FWD_UART;
         end
         default: ;
      endcase
   end

   assign rsp.valid = busy_ff;
   assign rsp.last  = (step_ff == STEP_FWD) || ((step_ff == STEP_COL_SEL) && !fwd_ff);

   // a tick starts its write sequence from the top on the next cycle
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      tick_xfer |=> rsp.valid && (step_ff == STEP_CLEAR_COL))
      else $error("tick did not start write sequence");

   // the final write ends the sequence unless a new tick is taken with it
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      last_xfer && !tick_xfer |=> !rsp.valid)
      else $error("sequence continued past final write");

   // forward write only follows a frame that asked for it
   a_fwd_step: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (step_ff == STEP_FWD) |-> fwd_ff)
      else $error("forward write without forwarding frame");

   // a pending frame is held, bytes dropped, until a tick consumes it
   a_pending_hold: assert property (@(posedge clock) disable iff (reset)
      pending_ff && !tick_xfer |=> pending_ff && $stable(frame_ff[2]))
      else $error("pending frame lost before tick");

endmodule

@@ test/lmsc_scan_checker.sv @@
// Scoreboard for the LED matrix scan controller: tracks frame and scan state,
// predicts each tick's shift-register writes and compares them in order.
// Depends on lmsc_pkg and the lmsc_req_if / lmsc_rsp_if channel interfaces.
`timescale 1ns / 1ps

module lmsc_scan_checker (
   input  logic clock,
   input  logic reset,
   lmsc_req_if  req,
   lmsc_rsp_if  rsp,
   output int   mismatch_count,
   output int   writes_outstanding
);

   localparam int BW = lmsc_pkg::BYTE_W;
   localparam int XW = lmsc_pkg::IDX_W;

   typedef struct packed {
      logic [BW-1:0]        value;
      lmsc_pkg::target_type target;
      logic                 last;
   } shift_write_type;

   shift_write_type   expected_writes[$];
   shift_write_type   oldest;
   logic              write_bad;

   logic [15:0]       led_rows[lmsc_pkg::ROWS];
   logic [BW-1:0]     matrix_cols[lmsc_pkg::ROWS];
   logic [BW-1:0]     frame_bytes[3];
   logic [1:0]        frame_count;
   logic              frame_pending;
   logic [XW-1:0]     row_index;
   logic [XW-1:0]     col_index;

   function automatic void queue_write(logic [BW-1:0] value,
                                       lmsc_pkg::target_type target, logic last);
      shift_write_type w;
      w.value  = value;
      w.target = target;
      w.last   = last;
      expected_writes.push_back(w);
   endfunction

   function automatic void take_serial_byte(logic [BW-1:0] rx);
      // bytes arriving while a complete frame waits are dropped
      if (!frame_pending) begin
         frame_bytes[frame_count] = rx;
         if (frame_count == 2'd2) begin
            frame_count   = '0;
            frame_pending = 1'b1;
         end else begin
            frame_count = frame_count + 2'd1;
         end
      end
   endfunction

   function automatic void predict_scan_tick();
      logic [BW-1:0] m;
      logic [BW-1:0] b0;
      logic [BW-1:0] b1;
      logic [BW-1:0] sel;
      logic [XW-1:0] row_sel;
      logic          forward;
      m       = matrix_cols[col_index];
      b0      = frame_bytes[0];
      b1      = frame_bytes[1];
      sel     = frame_bytes[2];
      forward = frame_pending && (sel == lmsc_pkg::SEL_FWD);

      queue_write('0, lmsc_pkg::TGT_LED_COL, 1'b0);
      queue_write(led_rows[row_index][7:0], lmsc_pkg::TGT_LED_ROW_LO, 1'b0);
      queue_write(led_rows[row_index][15:8], lmsc_pkg::TGT_LED_ROW_HI, 1'b0);
      queue_write(8'b1 << row_index, lmsc_pkg::TGT_LED_COL, 1'b0);
      queue_write('0, lmsc_pkg::TGT_MTX_COMMON, 1'b0);
      // fixed color split: 7-6 blue, 5-4 red, 3-2 red+green, 1-0 green
      if (col_index >= 3'd6) begin
         queue_write(m, lmsc_pkg::TGT_BLUE, 1'b0);
         queue_write('0, lmsc_pkg::TGT_RED, 1'b0);
         queue_write('0, lmsc_pkg::TGT_GREEN, 1'b0);
      end else if (col_index >= 3'd4) begin
         queue_write(m, lmsc_pkg::TGT_RED, 1'b0);
         queue_write('0, lmsc_pkg::TGT_BLUE, 1'b0);
         queue_write('0, lmsc_pkg::TGT_GREEN, 1'b0);
      end else if (col_index >= 3'd2) begin
         queue_write(m, lmsc_pkg::TGT_RED, 1'b0);
         queue_write(m, lmsc_pkg::TGT_GREEN, 1'b0);
         queue_write('0, lmsc_pkg::TGT_BLUE, 1'b0);
      end else begin
         queue_write(m, lmsc_pkg::TGT_GREEN, 1'b0);
         queue_write('0, lmsc_pkg::TGT_BLUE, 1'b0);
         queue_write('0, lmsc_pkg::TGT_RED, 1'b0);
      end
      queue_write(8'b1 << col_index, lmsc_pkg::TGT_MTX_COMMON, !forward);

      row_index = row_index + 3'd1;
      col_index = col_index - 3'd1;

      // pending frame takes effect after this tick's writes
      if (frame_pending) begin
         case (sel)
            lmsc_pkg::SEL_Q: begin
               matrix_cols[7] = b0;
               matrix_cols[6] = b1;
            end
            lmsc_pkg::SEL_W: begin
               matrix_cols[5] = b0;
               matrix_cols[4] = b1;
            end
            lmsc_pkg::SEL_E: begin
               matrix_cols[3] = b0;
               matrix_cols[2] = b1;
            end
            lmsc_pkg::SEL_R: begin
               matrix_cols[1] = b0;
               matrix_cols[0] = b1;
            end
            default: begin
               if (sel != '0 && sel <= lmsc_pkg::SEL_FWD) begin
                  row_sel           = sel[XW-1:0] - 3'd1;
                  led_rows[row_sel] = {b1, b0};
               end
            end
         endcase
         if (forward)
            queue_write(b1, lmsc_pkg::TGT_FWD_UART, 1'b1);
         frame_pending = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lmsc_pkg::ROWS; i++) begin
            led_rows[i]    = '0;
            matrix_cols[i] = '0;
         end
         for (int i = 0; i < 3; i++)
            frame_bytes[i] = '0;
         frame_count   = '0;
         frame_pending = 1'b0;
         row_index     = '0;
         col_index     = '0;
         expected_writes.delete();
      end else begin
         // a write leaving now belongs to an earlier tick, so check before predicting
         if (rsp.valid && rsp.ready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t ERROR write with nothing expected: byte %02h target %0d last %0b",
                        $time, rsp.out_byte, rsp.latch_target, rsp.last);
               mismatch_count++;
            end else begin
               oldest    = expected_writes.pop_front();
               write_bad = 1'b0;
               if (rsp.out_byte !== oldest.value) begin
                  $display("%0t ERROR out_byte expected %02h actual %02h",
                           $time, oldest.value, rsp.out_byte);
                  write_bad = 1'b1;
               end
               if (rsp.latch_target !== oldest.target) begin
                  $display("%0t ERROR latch_target expected %0d actual %0d",
                           $time, oldest.target, rsp.latch_target);
                  write_bad = 1'b1;
               end
               if (rsp.last !== oldest.last) begin
                  $display("%0t ERROR last expected %0b actual %0b",
                           $time, oldest.last, rsp.last);
                  write_bad = 1'b1;
               end
               if (write_bad)
                  mismatch_count++;
            end
         end
         if (req.valid && req.ready) begin
            if (req.req_type == lmsc_pkg::REQ_TICK)
               predict_scan_tick();
            else
               take_serial_byte(req.rx_byte);
         end
      end
      writes_outstanding = expected_writes.size();
   end

endmodule

@@ test/tb_led_matrix_scan_controller_top.sv @@
// Testbench top for led_matrix_scan_controller_top: clock, reset, request and
// response stimulus with random gaps and stalls, and the final verdict.
// Depends on lmsc_pkg, the channel interfaces and lmsc_scan_checker.
`timescale 1ns / 1ps

module tb_led_matrix_scan_controller_top;

   localparam int                BW            = lmsc_pkg::BYTE_W;
   localparam int                CLK_PERIOD    = 20;
   localparam int                RESET_CYCLES  = 7;
   localparam int                ITEM_TARGET   = 310;
   localparam int                MAX_WAIT      = 12;
   localparam int                HOLD_AFTER    = 100;
   localparam int                HOLD_CYCLES   = 400;
   localparam int                DRAIN_CYCLES  = 40;
   localparam int                CYCLE_LIMIT   = 300000;
   localparam logic [BW-1:0]     ROW_SEL_FIRST = 8'd1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int   mismatch_count;
   int   writes_outstanding;
   int   cycle_count   = 0;
   int   items_sent    = 0;
   int   frame_fill    = 0;
   bit   frame_held    = 1'b0;
   bit   req_no_gaps   = 1'b0;
   bit   rsp_no_stalls = 1'b0;
   int   writes_taken  = 0;
   bit   hold_done     = 1'b0;

   lmsc_req_if req_ch ();
   lmsc_rsp_if rsp_ch ();

   led_matrix_scan_controller_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   lmsc_scan_checker scoreboard (
      .clock              (clock),
      .reset              (reset),
      .req                (req_ch),
      .rsp                (rsp_ch),
      .mismatch_count     (mismatch_count),
      .writes_outstanding (writes_outstanding)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // valid is only dropped when a gap is drawn, so back-to-back transfers keep it high
   task automatic send_item(input logic kind, input logic [BW-1:0] data);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.rx_byte  <= data;
      do @(posedge clock); while (!req_ch.ready);
      // bytes dropped behind a waiting frame are not counted
      if (kind == lmsc_pkg::REQ_TICK) begin
         frame_held = 1'b0;
         items_sent++;
      end else if (!frame_held) begin
         items_sent++;
         if (frame_fill == 2) begin
            frame_fill = 0;
            frame_held = 1'b1;
         end else begin
            frame_fill++;
         end
      end
   endtask

   task automatic send_tick();
      send_item(lmsc_pkg::REQ_TICK, 8'($urandom));
   endtask

   task automatic send_frame(input logic [BW-1:0] b0, input logic [BW-1:0] b1,
                             input logic [BW-1:0] sel);
      send_item(lmsc_pkg::REQ_SERIAL, b0);
      send_item(lmsc_pkg::REQ_SERIAL, b1);
      send_item(lmsc_pkg::REQ_SERIAL, sel);
   endtask

   // response side: random stalls, one long hold-off to back the block up
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && writes_taken >= HOLD_AFTER) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = rsp_no_stalls ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         writes_taken++;
         if ($urandom_range(0, 19) == 0)
            rsp_no_stalls = !rsp_no_stalls;
      end
   end

   initial begin
      int            choice;
      int            pick;
      logic [BW-1:0] sel;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= lmsc_pkg::REQ_SERIAL;
      req_ch.rx_byte  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: cleared state, forward, dropped byte, matrix loads, bad selector
      send_tick();
      send_frame(8'h00, 8'hFF, lmsc_pkg::SEL_FWD);
      send_item(lmsc_pkg::REQ_SERIAL, 8'h55);
      send_tick();
      send_frame(8'hA5, 8'h5A, lmsc_pkg::SEL_Q);
      send_tick();
      send_frame(8'hFF, 8'h00, ROW_SEL_FIRST);
      send_tick();
      send_frame(8'h3C, 8'hC3, lmsc_pkg::SEL_E);
      send_tick();
      send_frame(8'h12, 8'h34, 8'hFF);
      send_tick();
      send_frame(8'h81, 8'h7E, lmsc_pkg::SEL_R);
      send_tick();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0)
            req_no_gaps = !req_no_gaps;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            choice = $urandom_range(0, 13);
            if (choice < 8)
               sel = 8'(choice + 1);
            else if (choice == 8)
               sel = lmsc_pkg::SEL_Q;
            else if (choice == 9)
               sel = lmsc_pkg::SEL_W;
            else if (choice == 10)
               sel = lmsc_pkg::SEL_E;
            else if (choice == 11)
               sel = lmsc_pkg::SEL_R;
            else
               sel = 8'($urandom_range(0, 255));
            send_frame(8'($urandom), 8'($urandom), sel);
            repeat ($urandom_range(1, 3)) send_tick();
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 2)) send_tick();
         end else begin
            // stray bytes: misalign frames or get dropped
            repeat ($urandom_range(1, 4)) send_item(lmsc_pkg::REQ_SERIAL, 8'($urandom));
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (writes_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && writes_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
